// ----- rtl/core/mi3_pkg.sv -----
package mi3_pkg;

    typedef struct packed {
        logic signed [31:0] a_00;
        logic signed [31:0] a_01;
        logic signed [31:0] a_02;
        logic signed [31:0] a_10;
        logic signed [31:0] a_11;
        logic signed [31:0] a_12;
        logic signed [31:0] a_20;
        logic signed [31:0] a_21;
        logic signed [31:0] a_22;
    } mi3_in_t;

    typedef struct packed {
        logic signed [31:0] inv_00;
        logic signed [31:0] inv_01;
        logic signed [31:0] inv_02;
        logic signed [31:0] inv_10;
        logic signed [31:0] inv_11;
        logic signed [31:0] inv_12;
        logic signed [31:0] inv_20;
        logic signed [31:0] inv_21;
        logic signed [31:0] inv_22;
        logic               invertible;
        logic               saturated;
    } mi3_out_t;

    localparam int unsigned CofW = 65;   // signed cofactor width
    localparam int unsigned DetW = 97;   // signed determinant width
    localparam int unsigned MagW = 96;   // determinant magnitude width
    localparam int unsigned NumW = 128;  // shifted numerator width

    // work passed from the front part to the back part through the queue
    typedef struct packed {
        logic [8:0][CofW-1:0] adj;
        logic [MagW-1:0]      dmag;
        logic                 dneg;
        logic                 nonzero;
    } mi3_job_t;

endpackage

// ----- rtl/core/matrix_inverse_3x3_unit.sv -----
// 3x3 matrix inverse, signed Q16.16, adjugate over exact determinant
// input channel: in_valid / in_stall / in_data carries one matrix per item
// output channel: out_valid / out_stall / out_data carries the nine inverse
//   elements, invertible and saturated for each item, in input order
// front part forms nine cofactors (one 32x32 pair per cycle) and the
//   determinant (one term per cycle)
// a two-entry queue decouples front and back
// back part runs a shared restoring divider at 4 quotient bits per cycle:
//   the nine elements one after another, then the next item;
//   that divider sets the throughput; a singular matrix skips the division
// a singular matrix gives zeros with invertible low
// out_stall holds the result in place; the front keeps working into the
//   queue until it fills; in_stall is high while the front holds an item
// reset clears the state machines, the front counter and the queue pointers; no items are in flight after reset
module matrix_inverse_3x3_unit #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  mi3_pkg::mi3_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output mi3_pkg::mi3_out_t out_data
);
    import mi3_pkg::*;

    logic        f_valid, f_stall, b_valid, b_stall;
    mi3_job_t    f_job, b_job;

    mi3_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .job_valid(f_valid), .job_stall(f_stall), .job_data(f_job)
    );

    mi3_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_job),
        .rd_valid(b_valid), .rd_stall(b_stall), .rd_data(b_job)
    );

    // numerator is shifted by twice the fraction width
    mi3_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(b_valid), .job_stall(b_stall), .job_data(b_job),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

`ifndef NO_ASSERTIONS
    // a singular result never reports saturation
    a_sing_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.invertible |-> !out_data.saturated)
        else $error("singular result flagged saturated");
    // a held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output changed under stall");
`endif
endmodule

// ----- rtl/core/mi3_front.sv -----
module mi3_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  mi3_pkg::mi3_in_t in_data,
    output logic             job_valid,
    input  logic             job_stall,
    output mi3_pkg::mi3_job_t job_data
);
    import mi3_pkg::*;

    // sequencer: 9 cofactor products x2 (32x32), then 3 det terms (33x32 halves), one mult pair per cycle
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_COF  = 4'b0010,
        S_DET  = 4'b0100,
        S_OUT  = 4'b1000
    } fstate_t;

    fstate_t state_reg, state_next;
    logic [3:0] idx_reg, idx_next;
    logic signed [31:0] a_reg [9];
    logic [8:0][CofW-1:0] adj_reg;
    logic signed [DetW-1:0] det_reg;
    logic signed [63:0] p_reg, q_reg;
    logic prod_vld_reg;
    logic [3:0] pidx_reg;

    logic signed [31:0] m0, m1, m2, m3;
    logic signed [63:0] p, q;
    logic [MagW:0] dabs;

    always_comb
    begin
        m0 = '0; m1 = '0; m2 = '0; m3 = '0;
        case (idx_reg)
            4'd0: begin m0 = a_reg[4]; m1 = a_reg[8]; m2 = a_reg[5]; m3 = a_reg[7]; end
            4'd1: begin m0 = a_reg[2]; m1 = a_reg[7]; m2 = a_reg[1]; m3 = a_reg[8]; end
            4'd2: begin m0 = a_reg[1]; m1 = a_reg[5]; m2 = a_reg[2]; m3 = a_reg[4]; end
            4'd3: begin m0 = a_reg[5]; m1 = a_reg[6]; m2 = a_reg[3]; m3 = a_reg[8]; end
            4'd4: begin m0 = a_reg[0]; m1 = a_reg[8]; m2 = a_reg[2]; m3 = a_reg[6]; end
            4'd5: begin m0 = a_reg[2]; m1 = a_reg[3]; m2 = a_reg[0]; m3 = a_reg[5]; end
            4'd6: begin m0 = a_reg[3]; m1 = a_reg[7]; m2 = a_reg[4]; m3 = a_reg[6]; end
            4'd7: begin m0 = a_reg[1]; m1 = a_reg[6]; m2 = a_reg[0]; m3 = a_reg[7]; end
            4'd8: begin m0 = a_reg[0]; m1 = a_reg[4]; m2 = a_reg[1]; m3 = a_reg[3]; end
            default: ;
        endcase
        p = m0 * m1;
        q = m2 * m3;
    end

    // det term: 65-bit cofactor times 32-bit element, split in two 33x32 halves
    logic signed [CofW-1:0] dc;
    logic signed [31:0]     de;
    logic signed [DetW-1:0] dterm;
    logic signed [64:0]     lo_prod;
    logic signed [64:0]     hi_prod;
    always_comb
    begin
        dc = '0; de = '0;
        case (idx_reg)
            4'd0: begin dc = adj_reg[0]; de = a_reg[0]; end
            4'd1: begin dc = adj_reg[3]; de = a_reg[1]; end
            4'd2: begin dc = adj_reg[6]; de = a_reg[2]; end
            default: ;
        endcase
        lo_prod = $signed({1'b0, dc[31:0]}) * de;
        hi_prod = $signed(dc[CofW-1:32]) * de;
        dterm = DetW'(lo_prod) + (DetW'(hi_prod) <<< 32);
    end

    assign dabs = det_reg[DetW-1] ? (MagW+1)'(-det_reg) : (MagW+1)'(det_reg);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    state_next = S_COF;
                    idx_next   = '0;
                end
            S_COF:
                if (idx_reg == 4'd9)
                begin
                    state_next = S_DET;
                    idx_next   = '0;
                end
                else
                    idx_next = idx_reg + 4'd1;
            S_DET:
                if (idx_reg == 4'd3)
                    state_next = S_OUT;
                else
                    idx_next = idx_reg + 4'd1;
            S_OUT:
                if (!job_stall)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign job_valid = (state_reg == S_OUT);
    assign job_data.adj     = adj_reg;
    assign job_data.dmag    = dabs[MagW-1:0];
    assign job_data.dneg    = det_reg[DetW-1];
    assign job_data.nonzero = (det_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            prod_vld_reg <= (state_reg == S_COF) && (idx_reg < 4'd9);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            a_reg[0] <= in_data.a_00; a_reg[1] <= in_data.a_01; a_reg[2] <= in_data.a_02;
            a_reg[3] <= in_data.a_10; a_reg[4] <= in_data.a_11; a_reg[5] <= in_data.a_12;
            a_reg[6] <= in_data.a_20; a_reg[7] <= in_data.a_21; a_reg[8] <= in_data.a_22;
        end
        p_reg    <= p;
        q_reg    <= q;
        pidx_reg <= idx_reg;
        if (prod_vld_reg)
            adj_reg[pidx_reg] <= CofW'(p_reg) - CofW'(q_reg);
        if (state_reg == S_COF && idx_reg == 4'd9)
            det_reg <= '0;
        else if (state_reg == S_DET && idx_reg < 4'd3)
            det_reg <= det_reg + dterm;
    end
endmodule

// ----- rtl/core/mi3_queue.sv -----
module mi3_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_stall,
    input  mi3_pkg::mi3_job_t wr_data,
    output logic              rd_valid,
    input  logic              rd_stall,
    output mi3_pkg::mi3_job_t rd_data
);
    import mi3_pkg::*;

    // two-entry queue
    mi3_job_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr_en, rd_en;

    assign wr_stall = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr_en    = wr_valid && !wr_stall;
    assign rd_en    = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end
endmodule

// ----- rtl/core/mi3_back.sv -----
module mi3_back #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_stall,
    input  mi3_pkg::mi3_job_t job_data,
    output logic              out_valid,
    input  logic              out_stall,
    output mi3_pkg::mi3_out_t out_data
);
    import mi3_pkg::*;

    // one restoring divider, 4 quotient bits per cycle, shared by all nine cofactors
    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_OUT  = 3'b100
    } bstate_t;

    localparam int unsigned Steps = 4;

    bstate_t state_reg, state_next;
    mi3_job_t job_reg;
    logic [3:0] eidx_reg;
    logic [5:0] cyc_reg;
    logic [NumW-1:0] num_reg;
    logic [MagW:0]   rem_reg;
    logic [NumW-1:0] q_reg;
    logic [8:0][31:0] res_reg;
    logic sat_reg;

    logic [CofW-1:0] cof;
    logic [MagW:0]   r [Steps+1];
    logic [NumW-1:0] qv [Steps+1];
    logic [NumW-1:0] nv [Steps+1];
    logic [MagW+1:0] t;
    logic neg, ovf;
    logic [31:0] val;

    assign cof  = job_reg.adj[eidx_reg];

    always_comb
    begin
        r[0] = rem_reg; qv[0] = q_reg; nv[0] = num_reg;
        for (int i = 0; i < Steps; i++)
        begin
            t = {r[i], nv[i][NumW-1]};
            nv[i+1] = nv[i] << 1;
            if (t >= {1'b0, job_reg.dmag, 1'b0} >> 1)
            begin
                r[i+1]  = (MagW+1)'(t - {2'b0, job_reg.dmag});
                qv[i+1] = {qv[i][NumW-2:0], 1'b1};
            end
            else
            begin
                r[i+1]  = (MagW+1)'(t);
                qv[i+1] = {qv[i][NumW-2:0], 1'b0};
            end
        end
        neg = cof[CofW-1] ^ job_reg.dneg;
        if (neg)
        begin
            ovf = (qv[Steps][NumW-1:32] != '0) || (qv[Steps][31:0] > 32'h8000_0000);
            val = ovf ? 32'h8000_0000 : 32'(-qv[Steps][31:0]);
        end
        else
        begin
            ovf = (qv[Steps][NumW-1:32] != '0) || qv[Steps][31];
            val = ovf ? 32'h7FFF_FFFF : qv[Steps][31:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
                if (job_valid)
                    state_next = B_DIV;
            B_DIV:
                if (!job_reg.nonzero || (eidx_reg == 4'd8 && cyc_reg == 6'd31))
                    state_next = B_OUT;
            B_OUT:
                if (!out_stall)
                    state_next = job_valid ? B_DIV : B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    logic take;
    assign take      = job_valid && (state_reg == B_IDLE || (state_reg == B_OUT && !out_stall));
    assign job_stall = !take;
    assign out_valid = (state_reg == B_OUT);
    assign out_data.inv_00 = res_reg[0];
    assign out_data.inv_01 = res_reg[1];
    assign out_data.inv_02 = res_reg[2];
    assign out_data.inv_10 = res_reg[3];
    assign out_data.inv_11 = res_reg[4];
    assign out_data.inv_12 = res_reg[5];
    assign out_data.inv_20 = res_reg[6];
    assign out_data.inv_21 = res_reg[7];
    assign out_data.inv_22 = res_reg[8];
    assign out_data.invertible = job_reg.nonzero;
    assign out_data.saturated  = sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg  <= job_data;
            eidx_reg <= '0;
            cyc_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
            num_reg  <= NumW'(job_data.adj[0][CofW-1] ? 64'(-job_data.adj[0])
                                                      : 64'(job_data.adj[0]))
                        << (2 * FRAC_BITS);
            res_reg  <= '0;
            sat_reg  <= 1'b0;
        end
        else if (state_reg == B_DIV && job_reg.nonzero)
        begin
            if (cyc_reg == 6'd31)
            begin
                res_reg[eidx_reg] <= val;
                sat_reg  <= sat_reg | ovf;
                eidx_reg <= eidx_reg + 4'd1;
                cyc_reg  <= '0;
                rem_reg  <= '0;
                q_reg    <= '0;
                if (eidx_reg != 4'd8)
                begin
                    num_reg <= NumW'(job_reg.adj[eidx_reg+4'd1][CofW-1]
                               ? 64'(-job_reg.adj[eidx_reg+4'd1])
                               : 64'(job_reg.adj[eidx_reg+4'd1])) << (2 * FRAC_BITS);
                end
            end
            else
            begin
                cyc_reg <= cyc_reg + 6'd1;
                rem_reg <= r[Steps];
                q_reg   <= qv[Steps];
                num_reg <= nv[Steps];
            end
        end
    end
endmodule

// ----- sim/mi3_checker.sv -----
import mi3_pkg::*;

module mi3_checker #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_stall,
    input  mi3_in_t  in_data,
    input  logic     out_valid,
    input  logic     out_stall,
    input  mi3_out_t out_data,
    output int       errors,
    output int       outstanding
);

    mi3_out_t inverse_q[$];

    initial errors = 0;
    initial outstanding = 0;

    // exact adjugate over determinant, clipped to 32 bits
    function automatic mi3_out_t invert_q16(mi3_in_t m);
        logic signed [127:0] e [9];
        logic signed [127:0] cof [9];
        logic signed [127:0] det;
        logic [127:0] dmag;
        logic [127:0] cmag;
        logic [127:0] quo;
        logic [31:0] v [9];
        logic neg;
        logic sat;
        mi3_out_t r;
        e[0] = $signed(m.a_00); e[1] = $signed(m.a_01); e[2] = $signed(m.a_02);
        e[3] = $signed(m.a_10); e[4] = $signed(m.a_11); e[5] = $signed(m.a_12);
        e[6] = $signed(m.a_20); e[7] = $signed(m.a_21); e[8] = $signed(m.a_22);
        cof[0] = e[4] * e[8] - e[5] * e[7];
        cof[1] = e[2] * e[7] - e[1] * e[8];
        cof[2] = e[1] * e[5] - e[2] * e[4];
        cof[3] = e[5] * e[6] - e[3] * e[8];
        cof[4] = e[0] * e[8] - e[2] * e[6];
        cof[5] = e[2] * e[3] - e[0] * e[5];
        cof[6] = e[3] * e[7] - e[4] * e[6];
        cof[7] = e[1] * e[6] - e[0] * e[7];
        cof[8] = e[0] * e[4] - e[1] * e[3];
        det = cof[0] * e[0] + cof[3] * e[1] + cof[6] * e[2];
        r = '0;
        if (det == 0)
            return r;
        dmag = det[127] ? -det : det;
        sat = 1'b0;
        for (int i = 0; i < 9; i++)
        begin
            neg = cof[i][127] ^ det[127];
            cmag = cof[i][127] ? -cof[i] : cof[i];
            quo = (cmag << (2 * FRAC_BITS)) / dmag;
            if (neg)
            begin
                if (quo > 128'h8000_0000)
                begin
                    v[i] = 32'h8000_0000;
                    sat = 1'b1;
                end
                else
                    v[i] = -quo[31:0];
            end
            else if (quo > 128'h7fff_ffff)
            begin
                v[i] = 32'h7fff_ffff;
                sat = 1'b1;
            end
            else
                v[i] = quo[31:0];
        end
        r.inv_00 = v[0]; r.inv_01 = v[1]; r.inv_02 = v[2];
        r.inv_10 = v[3]; r.inv_11 = v[4]; r.inv_12 = v[5];
        r.inv_20 = v[6]; r.inv_21 = v[7]; r.inv_22 = v[8];
        r.invertible = 1'b1;
        r.saturated = sat;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    task automatic check_inverse(mi3_out_t got, mi3_out_t want);
        if (got.inv_00 !== want.inv_00) report_mismatch("inv_00", got.inv_00, want.inv_00);
        if (got.inv_01 !== want.inv_01) report_mismatch("inv_01", got.inv_01, want.inv_01);
        if (got.inv_02 !== want.inv_02) report_mismatch("inv_02", got.inv_02, want.inv_02);
        if (got.inv_10 !== want.inv_10) report_mismatch("inv_10", got.inv_10, want.inv_10);
        if (got.inv_11 !== want.inv_11) report_mismatch("inv_11", got.inv_11, want.inv_11);
        if (got.inv_12 !== want.inv_12) report_mismatch("inv_12", got.inv_12, want.inv_12);
        if (got.inv_20 !== want.inv_20) report_mismatch("inv_20", got.inv_20, want.inv_20);
        if (got.inv_21 !== want.inv_21) report_mismatch("inv_21", got.inv_21, want.inv_21);
        if (got.inv_22 !== want.inv_22) report_mismatch("inv_22", got.inv_22, want.inv_22);
        if (got.invertible !== want.invertible)
            report_mismatch("invertible", got.invertible, want.invertible);
        if (got.saturated !== want.saturated)
            report_mismatch("saturated", got.saturated, want.saturated);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                inverse_q.push_back(invert_q16(in_data));
            if (out_valid && !out_stall)
            begin
                if (inverse_q.size() == 0)
                begin
                    $display("unexpected result item");
                    errors++;
                end
                else
                    check_inverse(out_data, inverse_q.pop_front());
            end
            outstanding = inverse_q.size();
        end
    end

endmodule

// ----- sim/tb_matrix_inverse_3x3_unit.sv -----
import mi3_pkg::*;

module tb_matrix_inverse_3x3_unit;

    localparam int ONE = 32'sh0001_0000;     // 1.0 in q16.16
    localparam int RANDOM_ITEMS = 1880;
    localparam int HOLD_CYCLES = 2500;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    mi3_in_t  in_data = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    mi3_out_t out_data;
    int       errors;
    int       outstanding;

    // receiver hold-off request, raised by the sender
    bit       hold_output = 1'b0;
    // when set, both sides run back to back
    bit       no_gaps = 1'b0;

    matrix_inverse_3x3_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    mi3_checker chk (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .errors(errors),
        .outstanding(outstanding)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // generous run limit: every item at the divider's full cost plus stalls
    initial
    begin
        #(20 * 4_000_000);
        $display("simulation failed");
        $finish;
    end

    function automatic mi3_in_t build_matrix(int a00, int a01, int a02, int a10, int a11,
                                             int a12, int a20, int a21, int a22);
        mi3_in_t m;
        m.a_00 = a00; m.a_01 = a01; m.a_02 = a02;
        m.a_10 = a10; m.a_11 = a11; m.a_12 = a12;
        m.a_20 = a20; m.a_21 = a21; m.a_22 = a22;
        return m;
    endfunction

    // element near unity scale, the usual control-loop range
    function automatic int near_unit();
        return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endfunction

    function automatic mi3_in_t random_matrix();
        mi3_in_t m;
        int unsigned kind;
        kind = $urandom_range(0, 9);
        if (kind < 2)
            m = {$urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
        else
        begin
            m = build_matrix(near_unit(), near_unit(), near_unit(), near_unit(), near_unit(),
                             near_unit(), near_unit(), near_unit(), near_unit());
            case (kind)
                // diagonal pushed out by four units toward dominance and good conditioning
                2, 3: begin
                    m.a_00 = m.a_00 + 4 * ONE;
                    m.a_11 = m.a_11 - 4 * ONE;
                    m.a_22 = m.a_22 + 4 * ONE;
                end
                // one element copied, then singular: one row repeats another
                4: m.a_20 = m.a_00;
                5: begin
                    m.a_20 = m.a_00; m.a_21 = m.a_01; m.a_22 = m.a_02;
                end
                // singular: a column repeats another
                6: begin
                    m.a_01 = m.a_00; m.a_11 = m.a_10; m.a_21 = m.a_20;
                end
                // tiny elements, quotients clip
                7: begin
                    m.a_00 = $signed($urandom_range(0, 8)) - 4;
                    m.a_11 = $signed($urandom_range(0, 8)) - 4;
                    m.a_22 = $signed($urandom_range(0, 8)) - 4;
                    m.a_01 = $signed($urandom_range(0, 4)) - 2;
                    m.a_12 = $signed($urandom_range(0, 4)) - 2;
                    m.a_20 = 0; m.a_10 = 0; m.a_21 = 0; m.a_02 = 0;
                end
                default: ;
            endcase
        end
        return m;
    endfunction

    // offers one item after a random gap (none with no_gaps) and waits for its handshake
    task automatic send_matrix(mi3_in_t m);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= m;
        do @(posedge clk); while (in_stall);
    endtask

    // result side: random stall per item (none with no_gaps), plus one long hold-off on request
    initial
    begin
        int unsigned wait_cycles;
        @(posedge rst_n);
        forever
        begin
            if (hold_output)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end
            wait_cycles = no_gaps ? 0 : $urandom_range(0, 11);
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        int drained;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity and scaled identity
        send_matrix(build_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
        send_matrix(build_matrix(2 * ONE, 0, 0, 0, -4 * ONE, 0, 0, 0, ONE / 2));
        // zero matrix and a rank-one matrix are singular
        send_matrix('0);
        send_matrix(build_matrix(ONE, 2 * ONE, 3 * ONE, 2 * ONE, 4 * ONE, 6 * ONE,
                                 -ONE, -2 * ONE, -3 * ONE));
        // general well-formed matrix
        send_matrix(build_matrix(2 * ONE, -ONE, 0, -ONE, 2 * ONE, -ONE, 0, -ONE, 2 * ONE));
        // tiny diagonal: positive clip, then negative clip
        send_matrix(build_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
        send_matrix(build_matrix(-1, 0, 0, 0, 1, 0, 0, 0, 1));
        // quotient exactly at the negative limit and one past the positive one
        send_matrix(build_matrix(-ONE / 32768, 0, 0, 0, ONE, 0, 0, 0, ONE));
        send_matrix(build_matrix(ONE / 32768, 0, 0, 0, ONE, 0, 0, 0, ONE));
        // field extremes
        send_matrix(build_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_matrix(build_matrix(32'h7fff_ffff, 0, 0, 0, 32'h7fff_ffff, 0,
                                 0, 0, 32'h7fff_ffff));
        send_matrix(build_matrix(32'h8000_0000, 32'h7fff_ffff, 0, 32'h7fff_ffff,
                                 32'h8000_0000, 32'h7fff_ffff, 0, 32'h7fff_ffff,
                                 32'h8000_0000));
        send_matrix(build_matrix(-1, -1, 0, 0, -1, -1, -1, 0, -1));
        send_matrix(build_matrix(32'h7fff_ffff, 32'h8000_0000, 1, -1, 32'h7fff_ffff,
                                 32'h8000_0000, 32'h8000_0000, 1, 32'h7fff_ffff));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // stretches with and without idle cycles, picked at random every 100 items
            if (n % 100 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            // long receiver hold-off while items keep coming
            if (n == 300)
                hold_output = 1'b1;
            // sender pause until everything has drained
            if (n == 900)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                wait (outstanding == 0);
                @(posedge clk);
            end
            send_matrix(random_matrix());
        end
        in_valid <= 1'b0;

        drained = 0;
        while (outstanding != 0 && drained < 200_000)
        begin
            @(posedge clk);
            drained++;
        end
        repeat (400) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
